FILE: hdl/psm_pkg.sv
// Shared types and constants for the partial statistics merge block.
package psm_pkg;

  localparam int COLUMNS  = 16;
  localparam int COL_W    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int CNT_W    = 40;
  localparam int VAL_W    = 48;
  localparam int M2_W     = 63;
  localparam int WIDE_W   = 128;
  localparam int DIV_W    = 42;
  localparam int STEP_W   = 7;

  localparam logic [VAL_W-1:0] MAXQ = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] MINQ = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [M2_W-1:0]  M2_SAT = {M2_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_SAT = {CNT_W{1'b1}};

  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic              go;
    alu_op_t           op;
    logic [WIDE_W-1:0] a;
    logic [63:0]       b;
    logic [STEP_W-1:0] steps;
  } alu_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [WIDE_W-1:0] res;
    logic [DIV_W-1:0]  rem;
  } alu_rsp_t;

endpackage

FILE: hdl/psm_alu.sv
// Shared bit-serial unit: shift-add multiply and restoring divide.
module psm_alu
  import psm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic              busy_r;
  logic              done_r;
  alu_op_t           op_r;
  logic [STEP_W-1:0] cnt_r;
  logic [WIDE_W-1:0] a_r;
  logic [63:0]       b_r;
  logic [WIDE_W-1:0] acc_r;
  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W-1:0]  d_r;

  logic [DIV_W:0]    rem_sh;
  logic              ge;
  logic [DIV_W:0]    rem_diff;

  assign rem_sh   = {rem_r, a_r[WIDE_W-1]};
  assign ge       = rem_sh >= {1'b0, d_r};
  assign rem_diff = rem_sh - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        busy_r <= 1'b1;
        op_r   <= req.op;
        cnt_r  <= req.steps;
        a_r    <= req.a;
        b_r    <= req.b;
        d_r    <= req.b[DIV_W-1:0];
        acc_r  <= '0;
        rem_r  <= '0;
      end else if (busy_r) begin
        unique case (op_r)
          ALU_MUL: begin
            if (b_r[0]) acc_r <= acc_r + a_r;
            a_r <= {a_r[WIDE_W-2:0], 1'b0};
            b_r <= {1'b0, b_r[63:1]};
          end
          ALU_DIV: begin
            rem_r <= ge ? rem_diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
            acc_r <= {acc_r[WIDE_W-2:0], ge};
            a_r   <= {a_r[WIDE_W-2:0], 1'b0};
          end
          default: ;
        endcase
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.res  = acc_r;
  assign rsp.rem  = rem_r;

endmodule

FILE: hdl/partial_statistics_merge.sv
// Top level: column store, merge sequencer and output register.
//
// Merges one column's partial statistics (count, mean, M2, min, max) per
// input transaction into a per-column store using the pairwise rule, and
// returns one result transaction with the merged values and the variance.
// Input: in_tdata carries the partial record, in_tuser the column index and
// in_tlast marks the last column of a record, which commits the shared count.
// Every arithmetic step runs on one shared bit-serial multiply/divide unit,
// one bit per cycle, under a step sequencer.
// With an empty stored count only the variance divide runs; otherwise ten
// serial steps run (two weighted-mean products, the mean divide, delta
// squared, the count product and its divide by the merged count, the
// products with quotient and remainder, the divide of the latter by the
// merged count and the variance divide), then the write-back; the variance
// step is skipped when the merged count is at most one. in_tready is high
// only while the sequencer is idle; one item is in work at a time. The
// result sits in an output register, so the next transaction is taken while
// a finished result still waits; a stalled receiver holds the sequencer only
// when a second result is ready to be written.
// Reset (rst_n low, synchronous) clears the count, means and M2 to zero and
// minima/maxima to the most positive/negative value.
module partial_statistics_merge
  import psm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // part_count[39:0], part_mean[87:40], part_m2[150:88], part_min[198:151],
  // part_max[246:199], zero pad
  input  logic [247:0] in_tdata,
  // column_index[3:0]
  input  logic [3:0]   in_tuser,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // merged_count[39:0], merged_mean[87:40], merged_m2[150:88],
  // merged_min[198:151], merged_max[246:199], sample_variance[309:247], pad
  output logic [311:0] out_tdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_A, S_MUL_B, S_DIV_MEAN, S_MUL_P, S_MUL_NN, S_DIV_NN,
    S_MUL_PQ, S_MUL_PR, S_DIV_PR, S_DIV_VAR, S_DONE
  } state_t;

  state_t state_r;

  // column store
  logic [VAL_W-1:0] mean_mem [COLUMNS];
  logic [M2_W-1:0]  m2_mem   [COLUMNS];
  logic [VAL_W-1:0] min_mem  [COLUMNS];
  logic [VAL_W-1:0] max_mem  [COLUMNS];
  logic [CNT_W-1:0] total_count_r;

  // captured transaction and working registers
  logic [COL_W-1:0] col_r;
  logic             valid_r;
  logic             last_r;
  logic [CNT_W-1:0] nb_r, na_r, cnt_r;
  logic [CNT_W:0]   n_r;
  logic [VAL_W-1:0] ma_r, mb_r, mn_r, mx_r, mean_r;
  logic [M2_W-1:0]  m2a_r, m2b_r, m2_r, var_r;
  logic [87:0]      prod_a_r;
  logic [81:0]      p_r;
  logic [CNT_W-1:0] q2_r;
  logic [CNT_W:0]   r_r;
  logic [WIDE_W-1:0] tmp_r, acc_r;
  logic             go_r;

  logic [311:0] out_data_r;
  logic         out_valid_r;

  alu_req_t req;
  alu_rsp_t rsp;

  // input field views
  logic [COL_W-1:0] in_col;
  logic             in_valid_col;
  logic [CNT_W-1:0] in_nb;
  logic [VAL_W-1:0] in_mb, in_min, in_max;
  logic [M2_W-1:0]  in_m2b;
  logic [VAL_W-1:0] st_mean, st_min, st_max;
  logic [M2_W-1:0]  st_m2;
  logic [CNT_W:0]   in_n;
  logic [CNT_W-1:0] in_cnt;

  assign in_nb        = in_tdata[39:0];
  assign in_mb        = in_tdata[87:40];
  assign in_m2b       = in_tdata[150:88];
  assign in_min       = in_tdata[198:151];
  assign in_max       = in_tdata[246:199];
  assign in_valid_col = 32'(in_tuser) < COLUMNS;
  assign in_col       = COL_W'(in_tuser);
  assign st_mean      = in_valid_col ? mean_mem[in_col] : '0;
  assign st_m2        = in_valid_col ? m2_mem[in_col]   : '0;
  assign st_min       = in_valid_col ? min_mem[in_col]  : MAXQ;
  assign st_max       = in_valid_col ? max_mem[in_col]  : MINQ;
  assign in_n         = {1'b0, total_count_r} + {1'b0, in_nb};
  assign in_cnt       = in_n[CNT_W] ? CNT_SAT : in_n[CNT_W-1:0];

  // signed-magnitude sum for the weighted mean
  logic [VAL_W-1:0] mag_a, mag_b;
  logic [88:0]      s_w;
  logic             neg_w;
  logic [VAL_W:0]   d_w;
  logic [VAL_W:0]   dm_w;

  assign mag_a = ma_r[VAL_W-1] ? (-ma_r) : ma_r;
  assign mag_b = mb_r[VAL_W-1] ? (-mb_r) : mb_r;

  always_comb begin
    priority if (ma_r[VAL_W-1] == mb_r[VAL_W-1]) begin
      s_w   = {1'b0, prod_a_r} + {1'b0, tmp_r[87:0]};
      neg_w = ma_r[VAL_W-1];
    end else if (prod_a_r < tmp_r[87:0]) begin
      s_w   = {1'b0, tmp_r[87:0] - prod_a_r};
      neg_w = mb_r[VAL_W-1];
    end else begin
      s_w   = {1'b0, prod_a_r - tmp_r[87:0]};
      neg_w = ma_r[VAL_W-1];
    end
  end

  assign d_w  = {mb_r[VAL_W-1], mb_r} - {ma_r[VAL_W-1], ma_r};
  assign dm_w = d_w[VAL_W] ? (-d_w) : d_w;

  // operands for the step about to start
  always_comb begin
    req.go    = go_r;
    req.op    = ALU_MUL;
    req.a     = '0;
    req.b     = '0;
    req.steps = STEP_W'(1);
    unique case (state_r)
      S_MUL_A: begin
        req.a = WIDE_W'(mag_a); req.b = 64'(na_r); req.steps = STEP_W'(40);
      end
      S_MUL_B: begin
        req.a = WIDE_W'(mag_b); req.b = 64'(nb_r); req.steps = STEP_W'(40);
      end
      S_DIV_MEAN: begin
        req.op = ALU_DIV; req.a = {s_w, 39'b0}; req.b = 64'(n_r);
        req.steps = STEP_W'(89);
      end
      S_MUL_P: begin
        req.a = WIDE_W'(dm_w); req.b = 64'(dm_w); req.steps = STEP_W'(49);
      end
      S_MUL_NN: begin
        req.a = WIDE_W'(na_r); req.b = 64'(nb_r); req.steps = STEP_W'(40);
      end
      S_DIV_NN: begin
        req.op = ALU_DIV; req.a = {tmp_r[79:0], 48'b0}; req.b = 64'(n_r);
        req.steps = STEP_W'(80);
      end
      S_MUL_PQ: begin
        req.a = WIDE_W'(p_r); req.b = 64'(q2_r); req.steps = STEP_W'(40);
      end
      S_MUL_PR: begin
        req.a = WIDE_W'(p_r); req.b = 64'(r_r); req.steps = STEP_W'(41);
      end
      S_DIV_PR: begin
        req.op = ALU_DIV; req.a = {tmp_r[122:0], 5'b0}; req.b = 64'(n_r);
        req.steps = STEP_W'(123);
      end
      S_DIV_VAR: begin
        req.op = ALU_DIV; req.a = {m2_r, 65'b0}; req.b = 64'(cnt_r - 1'b1);
        req.steps = STEP_W'(63);
      end
      default: ;
    endcase
  end

  psm_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  logic [WIDE_W-1:0] tot_w;
  logic [M2_W-1:0]   m2_sat_w;
  logic [VAL_W-1:0]  q_mean_w;
  logic              wb_go;

  assign tot_w    = acc_r + rsp.res;
  assign m2_sat_w = (tot_w[WIDE_W-1:M2_W] != '0) ? M2_SAT : tot_w[M2_W-1:0];
  assign q_mean_w = rsp.res[VAL_W-1:0];

  assign in_tready = (state_r == S_IDLE);

  // write back once the output register is free or being emptied
  assign wb_go = (state_r == S_DONE) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      go_r          <= 1'b0;
      out_valid_r   <= 1'b0;
      total_count_r <= '0;
      for (int c = 0; c < COLUMNS; c++) begin
        mean_mem[c] <= '0;
        m2_mem[c]   <= '0;
        min_mem[c]  <= MAXQ;
        max_mem[c]  <= MINQ;
      end
    end else begin
      go_r <= 1'b0;
      if (wb_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            // capture the transaction and fold min/max right away
            col_r   <= in_col;
            valid_r <= in_valid_col;
            last_r  <= in_tlast;
            nb_r    <= in_nb;
            na_r    <= total_count_r;
            n_r     <= in_n;
            cnt_r   <= in_cnt;
            ma_r    <= st_mean;
            mb_r    <= in_mb;
            m2a_r   <= st_m2;
            m2b_r   <= in_m2b;
            mn_r    <= ($signed(in_min) < $signed(st_min)) ? in_min : st_min;
            mx_r    <= ($signed(st_max) < $signed(in_max)) ? in_max : st_max;
            if (total_count_r == '0) begin
              mean_r <= in_mb;
              m2_r   <= in_m2b;
              if (in_cnt <= CNT_W'(1)) begin
                var_r   <= in_m2b;
                state_r <= S_DONE;
              end else begin
                state_r <= S_DIV_VAR;
                go_r    <= 1'b1;
              end
            end else begin
              state_r <= S_MUL_A;
              go_r    <= 1'b1;
            end
          end
        end
        S_MUL_A: if (rsp.done) begin
          prod_a_r <= rsp.res[87:0];
          state_r  <= S_MUL_B;
          go_r     <= 1'b1;
        end
        S_MUL_B: if (rsp.done) begin
          tmp_r   <= rsp.res;
          state_r <= S_DIV_MEAN;
          go_r    <= 1'b1;
        end
        S_DIV_MEAN: if (rsp.done) begin
          mean_r  <= neg_w ? (-q_mean_w) : q_mean_w;
          state_r <= S_MUL_P;
          go_r    <= 1'b1;
        end
        S_MUL_P: if (rsp.done) begin
          // drop 16 fraction bits of delta squared
          p_r     <= rsp.res[97:16];
          state_r <= S_MUL_NN;
          go_r    <= 1'b1;
        end
        S_MUL_NN: if (rsp.done) begin
          tmp_r   <= rsp.res;
          state_r <= S_DIV_NN;
          go_r    <= 1'b1;
        end
        S_DIV_NN: if (rsp.done) begin
          q2_r    <= rsp.res[CNT_W-1:0];
          r_r     <= rsp.rem[CNT_W:0];
          state_r <= S_MUL_PQ;
          go_r    <= 1'b1;
        end
        S_MUL_PQ: if (rsp.done) begin
          acc_r   <= rsp.res + WIDE_W'(m2a_r) + WIDE_W'(m2b_r);
          state_r <= S_MUL_PR;
          go_r    <= 1'b1;
        end
        S_MUL_PR: if (rsp.done) begin
          tmp_r   <= rsp.res;
          state_r <= S_DIV_PR;
          go_r    <= 1'b1;
        end
        S_DIV_PR: if (rsp.done) begin
          m2_r <= m2_sat_w;
          if (cnt_r <= CNT_W'(1)) begin
            var_r   <= m2_sat_w;
            state_r <= S_DONE;
          end else begin
            state_r <= S_DIV_VAR;
            go_r    <= 1'b1;
          end
        end
        S_DIV_VAR: if (rsp.done) begin
          var_r   <= rsp.res[M2_W-1:0];
          state_r <= S_DONE;
        end
        S_DONE: begin
          // hold here until the output register can take the result
          if (wb_go) begin
            out_data_r  <= {2'b0, var_r, mx_r, mn_r, m2_r, mean_r, cnt_r};
            if (valid_r) begin
              mean_mem[col_r] <= mean_r;
              m2_mem[col_r]   <= m2_r;
              min_mem[col_r]  <= mn_r;
              max_mem[col_r]  <= mx_r;
            end
            if (last_r) total_count_r <= cnt_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // no new transaction while the shared unit is iterating
  a_busy_idle: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.busy |-> !in_tready)
    else $error("input accepted while arithmetic unit busy");

  // a result only appears out of the write-back state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_DONE))
    else $error("result raised outside write-back");

  // variance never exceeds M2
  a_var_le: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[309:247] <= out_tdata[150:88]))
    else $error("variance above M2");

endmodule

FILE: tb/partial_statistics_merge_test.sv
// Testbench for partial_statistics_merge: directed and random merges against a built-in predictor.
`timescale 1ns / 1ps

module partial_statistics_merge_test;
  import psm_pkg::*;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [247:0] in_tdata = '0;
  logic [3:0]   in_tuser = '0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [311:0] out_tdata;

  typedef struct {
    logic [CNT_W-1:0] cnt;
    logic [VAL_W-1:0] mean;
    logic [M2_W-1:0]  m2;
    logic [VAL_W-1:0] vmin;
    logic [VAL_W-1:0] vmax;
    logic [M2_W-1:0]  var_q;
  } stats_t;

  // Predictor state: shared count and per-column store.
  logic [CNT_W-1:0] shared_count;
  logic [VAL_W-1:0] col_mean [COLUMNS];
  logic [M2_W-1:0]  col_m2   [COLUMNS];
  logic [VAL_W-1:0] col_min  [COLUMNS];
  logic [VAL_W-1:0] col_max  [COLUMNS];

  stats_t merged_q[$];
  int     errors = 0;
  bit     idle_on = 1'b1;
  bit     sink_hold = 1'b0;
  event   hold_ev;

  partial_statistics_merge i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  initial begin
    #40_000_000;
    $display("partial_statistics_merge_test failed");
    $finish;
  end

  // Merge one partial record into the predicted store and return the result.
  function automatic stats_t merge_partial(input logic [3:0] col, input logic [CNT_W-1:0] nb,
      input logic [VAL_W-1:0] mb, input logic [M2_W-1:0] m2b, input logic [VAL_W-1:0] pmin,
      input logic [VAL_W-1:0] pmax, input logic last);
    stats_t r;
    logic [CNT_W-1:0]   na;
    logic [CNT_W:0]     n;
    logic signed [47:0] sa, sb;
    logic signed [95:0] prod_a, prod_b, wsum, quot, ndiv;
    logic signed [48:0] delta;
    logic [48:0]        dmag;
    logic [97:0]        dsq;
    logic [199:0]       wide, tot;
    na = shared_count;
    n = {1'b0, na} + {1'b0, nb};
    r.cnt = n[CNT_W] ? CNT_SAT : n[CNT_W-1:0];
    r.vmin = ($signed(pmin) < $signed(col_min[col])) ? pmin : col_min[col];
    r.vmax = ($signed(pmax) > $signed(col_max[col])) ? pmax : col_max[col];
    if (na == 0) begin
      r.mean = mb;
      r.m2 = m2b;
    end else begin
      sa = col_mean[col];
      sb = mb;
      prod_a = sa * $signed({1'b0, na});
      prod_b = sb * $signed({1'b0, nb});
      wsum = prod_a + prod_b;
      ndiv = $signed({55'b0, n});
      quot = wsum / ndiv;
      r.mean = quot[VAL_W-1:0];
      delta = sb - sa;
      dmag = delta[48] ? -delta : delta;
      dsq = (dmag * dmag) >> 16;
      wide = dsq * na * nb;
      tot = col_m2[col] + m2b + wide / n;
      r.m2 = (tot > M2_SAT) ? M2_SAT : tot[M2_W-1:0];
    end
    r.var_q = (r.cnt <= 1) ? r.m2 : r.m2 / (r.cnt - 1);
    col_mean[col] = r.mean;
    col_m2[col] = r.m2;
    col_min[col] = r.vmin;
    col_max[col] = r.vmax;
    if (last) shared_count = r.cnt;
    return r;
  endfunction

  // Offer one partial record; keep valid high across back-to-back transactions.
  task automatic send_partial(input logic [3:0] col, input logic [CNT_W-1:0] nb,
      input logic [VAL_W-1:0] mb, input logic [M2_W-1:0] m2b, input logic [VAL_W-1:0] pmin,
      input logic [VAL_W-1:0] pmax, input logic last);
    if (idle_on && $urandom_range(99) < 9) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, pmax, pmin, m2b, mb, nb};
    in_tuser <= col;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    merged_q.insert(merged_q.size(), merge_partial(col, nb, mb, m2b, pmin, pmax, last));
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    wait (merged_q.size() == 0);
    @(posedge clk);
  endtask

  function automatic logic [VAL_W-1:0] rand_value();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(7))
      0: return MAXQ;
      1: return MINQ;
      2, 3, 4: return VAL_W'($signed(r[23:0]));
      default: return r[VAL_W-1:0];
    endcase
  endfunction

  function automatic logic [M2_W-1:0] rand_m2();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(7))
      0: return M2_SAT;
      1: return '0;
      2, 3, 4: return M2_W'(r[35:0]);
      default: return r[M2_W-1:0];
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] rand_count();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(19))
      0: return '0;
      1: return r[CNT_W-1:0] & 40'h00FFFFFFFF;
      default: return CNT_W'($urandom_range(1, 2000));
    endcase
  endfunction

  task automatic send_random_partial(input logic last);
    logic [VAL_W-1:0] a, b;
    a = rand_value();
    b = rand_value();
    if ($urandom_range(3) != 0 && $signed(a) > $signed(b)) {a, b} = {b, a};
    send_partial(4'($urandom_range(15)), rand_count(), rand_value(), rand_m2(), a, b, last);
  endtask

  // Empty store: zero count, both with an empty and a nonempty part; the last merges on a count of one.
  task automatic test_empty_store();
    send_partial(4'd0, '0, 48'h000000012345, 63'd77, 48'h000000010000, 48'h000000020000, 1'b1);
    send_partial(4'd1, '0, MINQ, '0, MAXQ, MINQ, 1'b1);
    send_partial(4'd1, 40'd1, 48'hFFFFFFFF0000, 63'd0, 48'hFFFFFFFF0000, 48'hFFFFFFFF0000, 1'b1);
    send_partial(4'd2, 40'd5, MAXQ, M2_SAT, MINQ, MAXQ, 1'b1);
    drain_results();
  endtask

  // Field extremes against a nonzero stored count, then random parts on random columns.
  task automatic test_field_extremes();
    send_partial(4'd2, 40'd3, MINQ, M2_SAT, MINQ, MAXQ, 1'b0);
    send_partial(4'd15, 40'd1, MAXQ, '0, MAXQ, MINQ, 1'b0);
    send_partial(4'd0, 40'd1000, MINQ, 63'd1, 48'd0, 48'd0, 1'b0);
    send_partial(4'd0, 40'd7, MAXQ, 63'h3FFF_FFFF_FFFF_FFFF, 48'd5, 48'd6, 1'b1);
    for (int c = 0; c < COLUMNS; c++) send_random_partial(c == COLUMNS - 1);
    drain_results();
  endtask

  // A record whose last column lacks tlast leaves the count uncommitted.
  task automatic test_unfinished_record();
    send_partial(4'd3, 40'd10, 48'h000000050000, 63'd100, 48'd1, 48'd9, 1'b0);
    send_partial(4'd4, 40'd10, 48'hFFFFFFFB0000, 63'd100, 48'd1, 48'd9, 1'b0);
    drain_results();
    send_partial(4'd3, 40'd2, 48'h000000010000, 63'd4, 48'd0, 48'd2, 1'b1);
    drain_results();
  endtask

  // Random records of random columns; a few are left unfinished.
  task automatic test_random_records(input int items);
    int sent, ncols;
    sent = 0;
    while (sent < items) begin
      ncols = $urandom_range(1, 6);
      for (int k = 0; k < ncols; k++)
        send_random_partial(k == ncols - 1 && $urandom_range(9) != 0);
      sent += ncols;
      if (sent > items / 3) idle_on = 1'b0;
      if (sent > 2 * items / 3) idle_on = 1'b1;
    end
    drain_results();
  endtask

  // Receiver holds off while the sender keeps offering, so the input stalls.
  task automatic test_backpressure();
    ->hold_ev;
    for (int k = 0; k < 6; k++) send_random_partial(k == 5);
    drain_results();
  endtask

  // Push the shared count to saturation.
  task automatic test_count_overflow();
    send_partial(4'd5, CNT_SAT, 48'h000000030000, 63'd50, 48'd0, 48'h000000030000, 1'b1);
    send_partial(4'd5, CNT_SAT, 48'hFFFFFFFD0000, 63'd50, MINQ, 48'd0, 1'b1);
    send_partial(4'd6, 40'd1, MAXQ, 63'd1, 48'd1, 48'd1, 1'b1);
    drain_results();
  endtask

  // Long hold-off, counted in cycles.
  initial forever begin
    @(hold_ev);
    sink_hold = 1'b1;
    repeat (2500) @(posedge clk);
    sink_hold = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= !sink_hold && !(idle_on && $urandom_range(99) < 9);
  end

  // Check each result transaction against the oldest prediction.
  always @(posedge clk) begin
    stats_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (merged_q.size() == 0) begin
        $display("%t unexpected result: actual %h", $time, out_tdata);
        errors++;
      end else begin
        e = merged_q.pop_front();
        if (out_tdata[39:0] !== e.cnt) begin
          $display("%t merged_count expected %h actual %h", $time, e.cnt, out_tdata[39:0]);
          errors++;
        end
        if (out_tdata[87:40] !== e.mean) begin
          $display("%t merged_mean expected %h actual %h", $time, e.mean, out_tdata[87:40]);
          errors++;
        end
        if (out_tdata[150:88] !== e.m2) begin
          $display("%t merged_m2 expected %h actual %h", $time, e.m2, out_tdata[150:88]);
          errors++;
        end
        if (out_tdata[198:151] !== e.vmin) begin
          $display("%t merged_min expected %h actual %h", $time, e.vmin, out_tdata[198:151]);
          errors++;
        end
        if (out_tdata[246:199] !== e.vmax) begin
          $display("%t merged_max expected %h actual %h", $time, e.vmax, out_tdata[246:199]);
          errors++;
        end
        if (out_tdata[309:247] !== e.var_q) begin
          $display("%t sample_variance expected %h actual %h", $time, e.var_q,
                   out_tdata[309:247]);
          errors++;
        end
      end
    end
  end

  initial begin
    shared_count = '0;
    for (int c = 0; c < COLUMNS; c++) begin
      col_mean[c] = '0;
      col_m2[c] = '0;
      col_min[c] = MAXQ;
      col_max[c] = MINQ;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_store();
    test_field_extremes();
    test_unfinished_record();
    test_random_records(900);
    test_backpressure();
    test_count_overflow();
    repeat (800) @(posedge clk);
    if (errors == 0 && merged_q.size() == 0) begin
      $display("partial_statistics_merge_test passed");
    end else begin
      $display("partial_statistics_merge_test failed");
    end
    $finish;
  end

endmodule
